FILE: hw/rtl/pcd_pkg.sv
package pcd_pkg;

    // table and code geometry
    localparam int TABLE_ENTRIES = 64;
    localparam int MAX_CODE_BITS = 16;
    localparam int SYMBOL_BITS   = 16;
    localparam int INDEX_W       = 6;
    localparam int CODE_W        = 16;
    localparam int LEN_W         = 5;
    localparam int KIND_W        = 2;
    localparam int STATUS_W      = 2;

    // word kinds
    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BIT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_SYMBOL     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_MATCH   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INCOMPLETE = 2'd2;

    // table write broadcast to every cell
    typedef struct packed {
        logic                   en;
        logic [INDEX_W-1:0]     index;
        logic [CODE_W-1:0]      code;
        logic [LEN_W-1:0]       length;
        logic [SYMBOL_BITS-1:0] symbol;
    } load_t;

    // pending code broadcast to every cell for the lookup
    typedef struct packed {
        logic [CODE_W-1:0] bits;
        logic [CODE_W-1:0] mask;
        logic [LEN_W-1:0]  count;
    } probe_t;

endpackage

FILE: hw/rtl/pcd_cell.sv
module pcd_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [pcd_pkg::INDEX_W-1:0]    cell_index,
    input  pcd_pkg::load_t                 load,
    input  pcd_pkg::probe_t                probe,
    output logic                           match,
    output logic [pcd_pkg::SYMBOL_BITS-1:0] symbol
);
    import pcd_pkg::*;

    logic [CODE_W-1:0]      code_reg;
    logic [LEN_W-1:0]       length_reg;
    logic [SYMBOL_BITS-1:0] symbol_reg;
    logic                   write_hit;

    assign write_hit = load.en && (load.index == cell_index);

    // slot length, zero means empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
        end
        else if (write_hit)
        begin
            length_reg <= load.length;
        end
    end

    // code and symbol of the slot
    always_ff @(posedge clk)
    begin
        if (write_hit)
        begin
            code_reg   <= load.code;
            symbol_reg <= load.symbol;
        end
    end

    // compare against the pending code, only its low count bits
    assign match = (length_reg != '0) && (length_reg == probe.count) &&
                   ((code_reg & probe.mask) == probe.bits);
    assign symbol = symbol_reg;

endmodule

FILE: hw/rtl/pcd_select.sv
module pcd_select (
    input  logic [pcd_pkg::TABLE_ENTRIES-1:0] match,
    input  logic [pcd_pkg::SYMBOL_BITS-1:0]   cell_symbol [pcd_pkg::TABLE_ENTRIES],
    output logic                              any_match,
    output logic [pcd_pkg::SYMBOL_BITS-1:0]   symbol
);
    import pcd_pkg::*;

    logic [TABLE_ENTRIES-1:0] lowest;

    // isolate the lowest matching slot
    assign lowest    = match & (~match + 1'b1);
    assign any_match = |match;

    // and-or mux over the one-hot select
    always_comb
    begin
        symbol = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            symbol = symbol | (cell_symbol[i] & {SYMBOL_BITS{lowest[i]}});
        end
    end

endmodule

FILE: hw/rtl/prefix_code_decoder.sv
// prefix code decoder: row of table cells matched against the pending code
// a result word is registered in the output register, or in the skid word while the output stalls
// input: one word per cycle while in_stall is low, one lookup per bit word
// a two-word output buffer lets input continue while a result waits
// reset clears every slot length (table empty), the pending code and the buffer
// code and symbol storage of a slot is not reset and is read only once loaded
module prefix_code_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [pcd_pkg::KIND_W-1:0]         kind,
    input  logic [pcd_pkg::INDEX_W-1:0]        entry_index,
    input  logic [pcd_pkg::CODE_W-1:0]         code_value,
    input  logic [pcd_pkg::LEN_W-1:0]          code_length,
    input  logic [pcd_pkg::SYMBOL_BITS-1:0]    symbol_in,
    input  logic                               code_bit,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [pcd_pkg::SYMBOL_BITS-1:0]    symbol,
    output logic [pcd_pkg::STATUS_W-1:0]       status
);
    import pcd_pkg::*;

    localparam int MASK_W = CODE_W + 1;

    logic                     accept;
    load_t                    load;
    probe_t                   probe;
    logic [MASK_W-1:0]        mask_wide;

    logic [CODE_W-1:0]        pend_bits_reg, pend_bits_next;
    logic [LEN_W-1:0]         pend_count_reg, pend_count_next;

    logic [TABLE_ENTRIES-1:0] cell_match;
    logic [SYMBOL_BITS-1:0]   cell_symbol [TABLE_ENTRIES];
    logic                     any_match;
    logic [SYMBOL_BITS-1:0]   hit_symbol;

    logic                     res_valid;
    logic [SYMBOL_BITS-1:0]   res_symbol;
    logic [STATUS_W-1:0]      res_status;

    logic                     main_valid_reg, main_valid_next;
    logic [SYMBOL_BITS-1:0]   main_symbol_reg, main_symbol_next;
    logic [STATUS_W-1:0]      main_status_reg, main_status_next;
    logic                     skid_valid_reg, skid_valid_next;
    logic [SYMBOL_BITS-1:0]   skid_symbol_reg, skid_symbol_next;
    logic [STATUS_W-1:0]      skid_status_reg, skid_status_next;
    logic                     main_free;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;

    // table write word
    assign load.en     = accept && (kind == KIND_LOAD);
    assign load.index  = entry_index;
    assign load.code   = code_value;
    assign load.length = code_length;
    assign load.symbol = symbol_in;

    // pending code with the new bit shifted in
    assign probe.count = pend_count_reg + 1'b1;
    assign mask_wide   = (MASK_W'(1) << probe.count) - 1'b1;
    assign probe.mask  = mask_wide[CODE_W-1:0];
    assign probe.bits  = {pend_bits_reg[CODE_W-2:0], code_bit} & probe.mask;

    // row of table cells
    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        pcd_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (INDEX_W'(g)),
            .load       (load),
            .probe      (probe),
            .match      (cell_match[g]),
            .symbol     (cell_symbol[g])
        );
    end

    pcd_select u_select (
        .match       (cell_match),
        .cell_symbol (cell_symbol),
        .any_match   (any_match),
        .symbol      (hit_symbol)
    );

    // decode step: result and next pending code
    always_comb
    begin
        res_valid       = 1'b0;
        res_symbol      = '0;
        res_status      = STATUS_SYMBOL;
        pend_bits_next  = pend_bits_reg;
        pend_count_next = pend_count_reg;
        if (accept)
        begin
            case (kind)
                KIND_BIT:
                begin
                    if (any_match)
                    begin
                        res_valid       = 1'b1;
                        res_symbol      = hit_symbol;
                        res_status      = STATUS_SYMBOL;
                        pend_bits_next  = '0;
                        pend_count_next = '0;
                    end
                    else if (probe.count >= LEN_W'(MAX_CODE_BITS))
                    begin
                        res_valid       = 1'b1;
                        res_status      = STATUS_NO_MATCH;
                        pend_bits_next  = '0;
                        pend_count_next = '0;
                    end
                    else
                    begin
                        pend_bits_next  = probe.bits;
                        pend_count_next = probe.count;
                    end
                end
                KIND_END:
                begin
                    if (pend_count_reg != '0)
                    begin
                        res_valid       = 1'b1;
                        res_status      = STATUS_INCOMPLETE;
                        pend_bits_next  = '0;
                        pend_count_next = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // output register plus skid word
    always_comb
    begin
        main_free        = !main_valid_reg || !out_stall;
        main_valid_next  = main_valid_reg;
        main_symbol_next = main_symbol_reg;
        main_status_next = main_status_reg;
        skid_valid_next  = skid_valid_reg;
        skid_symbol_next = skid_symbol_reg;
        skid_status_next = skid_status_reg;
        if (main_free)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next  = 1'b1;
                main_symbol_next = skid_symbol_reg;
                main_status_next = skid_status_reg;
                skid_valid_next  = 1'b0;
            end
            else
            begin
                main_valid_next  = res_valid;
                main_symbol_next = res_symbol;
                main_status_next = res_status;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next  = 1'b1;
            skid_symbol_next = res_symbol;
            skid_status_next = res_status;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg  <= '0;
            pend_count_reg <= '0;
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            pend_bits_reg  <= pend_bits_next;
            pend_count_reg <= pend_count_next;
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        main_symbol_reg <= main_symbol_next;
        main_status_reg <= main_status_next;
        skid_symbol_reg <= skid_symbol_next;
        skid_status_reg <= skid_status_next;
    end

    assign out_valid = main_valid_reg;
    assign symbol    = main_symbol_reg;
    assign status    = main_status_reg;

endmodule
